### rtl/core/fsd_pkg.sv
`default_nettype none

package fsd_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // The line store is split into even and odd columns so that the two
  // next-row entries finished at the end of a row go out in the same cycle.
  localparam int NUM_BANKS  = 2;
  localparam int BANK_DEPTH = MAX_WIDTH / NUM_BANKS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Configuration register widths and reset values.
  localparam int CFG_WIDTH_W  = 10;
  localparam int CFG_HEIGHT_W = 11;
  localparam int CFG_THRESH_W = 8;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(400);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(300);
  localparam logic [CFG_THRESH_W-1:0] THRESH_RESET = CFG_THRESH_W'(127);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2
  } cfg_idx_e;

  // Data path widths.
  localparam int PIXEL_W = 16;
  localparam int LUM_W   = 16;
  localparam int ERR_W   = 20;
  localparam int BYTE_W  = 8;

  // Luminance weights in 1/256 units; full-scale white gives 65274, FULL_SCALE is 65280.
  localparam int COEF_R     = 630;
  localparam int COEF_G     = 608;
  localparam int COEF_B     = 240;
  localparam int FULL_SCALE = 65280;

  localparam logic signed [ERR_W+1:0] ERR_MAX_X = (ERR_W+2)'((1 << (ERR_W-1)) - 1);
  localparam logic signed [ERR_W+1:0] ERR_MIN_X = -(ERR_W+2)'(1 << (ERR_W-1));

  typedef logic signed [ERR_W-1:0] err_t;

  // One pixel held between the front register and the diffusion stage.
  typedef struct packed {
    logic [LUM_W-1:0] lum;
    logic [COL_W-1:0] col;
    logic             row_zero;
    logic             last_col;
    logic             last_row;
    logic             emit;
  } stage_t;

  typedef struct packed {
    logic               we;
    logic [BANK_AW-1:0] addr;
    err_t               data;
  } bank_wr_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              row_end;
    logic              frame_end;
  } result_t;

  // Clamp a widened sum into the stored error range.
  function automatic err_t sat_err(input logic signed [ERR_W+1:0] v);
    err_t r;
    if (v > ERR_MAX_X) begin
      r = ERR_MAX_X[ERR_W-1:0];
    end else if (v < ERR_MIN_X) begin
      r = ERR_MIN_X[ERR_W-1:0];
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/fsd_line_bank.sv
`default_nettype none

module fsd_line_bank
  import fsd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rd_en_i,
  input  wire logic [BANK_AW-1:0] rd_addr_i,
  input  wire bank_wr_t           wr_i,
  output      err_t               rd_data_o
);

  err_t mem [BANK_DEPTH];
  err_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // A write landing on the address being read in the same cycle is passed
  // straight through, so a short row sees the value it just produced.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.we && (wr_i.addr == rd_addr_i)) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/core/fsd_front.sv
`default_nettype none

module fsd_front
  import fsd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output      logic                 ready_o,
  input  wire logic [PIXEL_W-1:0]   pixel_i,
  input  wire logic                 advance_i,
  input  wire logic [COL_W:0]       width_i,
  input  wire logic [ROW_W:0]       height_i,
  output      logic                 stage_valid_o,
  output      stage_t               stage_o,
  output      logic                 rd_en_o,
  output      logic [BANK_AW-1:0]   rd_addr_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             valid_q, valid_d;
  stage_t           stage_q, stage_d;
  logic             accept;
  logic             last_col, last_row;
  logic [4:0]       red, blue;
  logic [5:0]       green;

  assign ready_o = !valid_q || advance_i;
  assign accept  = valid_i && ready_o;

  assign red   = pixel_i[15:11];
  assign green = pixel_i[10:5];
  assign blue  = pixel_i[4:0];

  assign last_col = ({1'b0, col_q} + (COL_W+1)'(1)) >= width_i;
  assign last_row = ({1'b0, row_q} + (ROW_W+1)'(1)) >= height_i;

  // The line store is read for the incoming column as the item is taken.
  assign rd_en_o   = accept;
  assign rd_addr_o = col_q[COL_W-1:1];

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    valid_d = valid_q;
    stage_d = stage_q;
    if (advance_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d           = 1'b1;
      stage_d.lum       = LUM_W'(32'(red) * COEF_R + 32'(green) * COEF_G
                                 + 32'(blue) * COEF_B);
      stage_d.col       = col_q;
      stage_d.row_zero  = (row_q == '0);
      stage_d.last_col  = last_col;
      stage_d.last_row  = last_row;
      stage_d.emit      = last_col || (col_q[2:0] == 3'd7);
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_valid_o = valid_q;
  assign stage_o       = stage_q;

endmodule

`default_nettype wire

### rtl/core/fsd_diffuse.sv
`default_nettype none

module fsd_diffuse
  import fsd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    advance_i,
  input  wire stage_t                  stage_i,
  input  wire logic [CFG_THRESH_W-1:0] threshold_i,
  input  wire err_t                    rd_data_i [NUM_BANKS],
  output      bank_wr_t                wr_o [NUM_BANKS],
  output      result_t                 result_o
);

  err_t right_q, right_d;
  err_t pend_q, pend_d;
  err_t diag_q, diag_d;
  logic [BYTE_W-1:0] bits_q, bits_d;

  err_t                    cur;
  logic signed [ERR_W+1:0] sum;
  err_t                    val;
  logic signed [ERR_W+1:0] level;
  logic                    set;
  logic signed [ERR_W:0]   e;
  logic signed [ERR_W+3:0] ex, m7, m5, m3;
  err_t                    s7, s5, s3, s1;
  err_t                    left_val, tail_val, tail_next;
  logic [COL_W-1:0]        left_col;
  logic                    left_en;
  logic [BYTE_W-1:0]       bits_set;

  localparam logic signed [ERR_W:0] E_FULL = (ERR_W+1)'(FULL_SCALE);

  always_comb begin
    cur   = stage_i.row_zero ? '0 : rd_data_i[stage_i.col[0]];
    sum   = $signed((ERR_W+2)'(stage_i.lum)) + (ERR_W+2)'(right_q) + (ERR_W+2)'(cur);
    val   = sat_err(sum);
    level = $signed((ERR_W+2)'({threshold_i, 8'b0}));
    set   = (ERR_W+2)'(val) > level;
    e     = (ERR_W+1)'(val) - (set ? E_FULL : '0);

    // Shares of the error: small constant products, then floor by 16.
    ex = (ERR_W+4)'(e);
    m7 = (ex <<< 3) - ex;
    m5 = (ex <<< 2) + ex;
    m3 = (ex <<< 1) + ex;
    s7 = ERR_W'(m7 >>> 4);
    s5 = ERR_W'(m5 >>> 4);
    s3 = ERR_W'(m3 >>> 4);
    s1 = ERR_W'(ex >>> 4);

    left_val  = sat_err((ERR_W+2)'(pend_q) + (ERR_W+2)'(s3));
    tail_val  = sat_err((ERR_W+2)'(diag_q) + (ERR_W+2)'(s5));
    left_col  = stage_i.col - COL_W'(1);
    left_en   = (stage_i.col != '0);
    tail_next = stage_i.last_col ? '0 : tail_val;

    bits_set = bits_q | (set ? (BYTE_W'(8'h80) >> stage_i.col[2:0]) : '0);
  end

  // The finished entry left of the pixel and, at the end of a row, the entry
  // under the pixel itself; their columns differ in parity.
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      wr_o[b].we   = 1'b0;
      wr_o[b].addr = left_col[COL_W-1:1];
      wr_o[b].data = left_val;
      if (stage_i.last_col && (stage_i.col[0] == 1'(b))) begin
        wr_o[b].we   = advance_i;
        wr_o[b].addr = stage_i.col[COL_W-1:1];
        wr_o[b].data = tail_val;
      end else if (left_en && (left_col[0] == 1'(b))) begin
        wr_o[b].we = advance_i;
      end
    end
  end

  always_comb begin
    right_d = right_q;
    pend_d  = pend_q;
    diag_d  = diag_q;
    bits_d  = bits_q;
    if (advance_i) begin
      right_d = stage_i.last_col ? '0 : s7;
      pend_d  = tail_next;
      diag_d  = stage_i.last_col ? '0 : s1;
      bits_d  = stage_i.emit ? '0 : bits_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= '0;
      pend_q  <= '0;
      diag_q  <= '0;
      bits_q  <= '0;
    end else begin
      right_q <= right_d;
      pend_q  <= pend_d;
      diag_q  <= diag_d;
      bits_q  <= bits_d;
    end
  end

  assign result_o.packed_byte = bits_set;
  assign result_o.row_end     = stage_i.last_col;
  assign result_o.frame_end   = stage_i.last_col && stage_i.last_row;

endmodule

`default_nettype wire

### rtl/core/floyd_steinberg_dither.sv
`default_nettype none

// Floyd-Steinberg error diffusion of an RGB565 raster stream down to one bit
// per pixel. Pixels enter on the slave stream in raster order, one item per
// clock when the output side keeps up; each becomes a luminance, takes the
// error diffused from its neighbors, is compared against threshold*256, and
// its bit is packed most significant first into a byte. A byte item leaves
// on the master stream after every eighth pixel of a row and at row end
// (unused low bits zero); tlast marks the byte that closes a row and tuser
// the byte that closes the frame. Throughput is one pixel per cycle while
// the output side keeps up, set by the right-neighbor error loop in the
// diffusion stage; the next-row errors sit in a line store of two
// 256 x 20 bit banks (even and odd columns), one read and one write per bank
// per cycle. The line store has no clearing pass: the first row of a frame
// reads it as zero and every later entry is written before it is read. The
// user writes width, height and threshold through the configuration port
// only while the block is idle; the block does not enforce it. Width is
// clamped to 1..512 and height to 1..1024.
module floyd_steinberg_dither
  import fsd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,

  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [PIXEL_W-1:0]    s_axis_tdata,   // [15:0] pixel

  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [BYTE_W-1:0]     m_axis_tdata,   // [7:0] packed_byte
  output      logic                  m_axis_tlast,   // row_end
  output      logic                  m_axis_tuser    // [0] frame_end
);

  // Configuration registers.
  logic [CFG_WIDTH_W-1:0]  width_q, width_d;
  logic [CFG_HEIGHT_W-1:0] height_q, height_d;
  logic [CFG_THRESH_W-1:0] thresh_q, thresh_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    thresh_d = thresh_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_d  = cfg_wdata_i[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_d = cfg_wdata_i[CFG_HEIGHT_W-1:0];
        CFG_THRESHOLD:    thresh_d = cfg_wdata_i[CFG_THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      thresh_q <= THRESH_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      thresh_q <= thresh_d;
    end
  end

  // Effective frame size after clamping to the supported range.
  logic [COL_W:0] width_eff;
  logic [ROW_W:0] height_eff;

  always_comb begin
    if (width_q == '0) begin
      width_eff = (COL_W+1)'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      width_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      width_eff = (COL_W+1)'(width_q);
    end
    if (height_q == '0) begin
      height_eff = (ROW_W+1)'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      height_eff = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      height_eff = (ROW_W+1)'(height_q);
    end
  end

  // Pixel stage, line store and diffusion stage.
  logic               stage_valid;
  stage_t             stage;
  logic               advance;
  logic               rd_en;
  logic [BANK_AW-1:0] rd_addr;
  err_t               rd_data [NUM_BANKS];
  bank_wr_t           bank_wr [NUM_BANKS];
  result_t            result;

  // Output register state.
  logic    out_valid_q, out_valid_d;
  result_t out_res_q, out_res_d;

  // A pixel that produces no byte never waits on the output side.
  assign advance = stage_valid && (!stage.emit || !out_valid_q || m_axis_tready);

  fsd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .pixel_i       (s_axis_tdata),
    .advance_i     (advance),
    .width_i       (width_eff),
    .height_i      (height_eff),
    .stage_valid_o (stage_valid),
    .stage_o       (stage),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr)
  );

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    fsd_line_bank u_bank (
      .clk_i     (clk_i),
      .rd_en_i   (rd_en),
      .rd_addr_i (rd_addr),
      .wr_i      (bank_wr[b]),
      .rd_data_o (rd_data[b])
    );
  end

  fsd_diffuse u_diffuse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .stage_i     (stage),
    .threshold_i (thresh_q),
    .rd_data_i   (rd_data),
    .wr_o        (bank_wr),
    .result_o    (result)
  );

  // The output register holds a finished byte while the next pixels keep
  // flowing through the front stage.
  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance && stage.emit) begin
      out_valid_d = 1'b1;
      out_res_d   = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.packed_byte;
  assign m_axis_tlast  = out_res_q.row_end;
  assign m_axis_tuser  = out_res_q.frame_end;

endmodule

`default_nettype wire
